@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RSSI Kalman filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define PDRK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define PDRK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pdrk_pkg.sv @@
// Package with the constants, types and codes of the RSSI Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package pdrk_pkg;

	localparam int SLOT_COUNT      = 64;
	localparam int RSSI_BITS       = 16;
	localparam int VARIANCE_BITS   = 18;
	localparam int SLOT_FIELD_BITS = 6;
	localparam int CFG_BITS        = 18;
	localparam int CFG_IDX_W       = 1;
	localparam int GAIN_W          = 16;

	localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SUM_W   = ((VARIANCE_BITS > CFG_BITS) ? VARIANCE_BITS : CFG_BITS) + 1;
	localparam int MUL_A_W = GAIN_W + 2;
	localparam int MUL_B_W = ((RSSI_BITS + 1 > VARIANCE_BITS) ? RSSI_BITS + 1 : VARIANCE_BITS) + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int IN_DATA_W  = ((SLOT_FIELD_BITS + RSSI_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SLOT_FIELD_BITS + RSSI_BITS + 7) / 8) * 8;

	localparam logic [GAIN_W:0]          ONE_Q16  = {1'b1, {GAIN_W{1'b0}}};
	localparam logic [GAIN_W-1:0]        GAIN_MAX = '1;
	localparam logic [VARIANCE_BITS-1:0] VAR_MAX  = '1;
	localparam logic [VARIANCE_BITS-1:0] VAR_INIT =
		(VARIANCE_BITS > GAIN_W) ? VARIANCE_BITS'(ONE_Q16) : VAR_MAX;

	localparam logic [CFG_BITS-1:0] PROCESS_NOISE_RESET     = CFG_BITS'(66);
	localparam logic [CFG_BITS-1:0] MEASUREMENT_NOISE_RESET = CFG_BITS'(6554);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE,
		REG_MEASUREMENT_NOISE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL_EST,
		ST_MUL_VAR,
		ST_VAR,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] quotient;
	} div_result_t;

endpackage
`default_nettype wire

@@ rtl/pdrk_ram.sv @@
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module pdrk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                            wdata,
	output      logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/pdrk_div.sv @@
// Iterative restoring divider that forms the filter gain one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pdrk_div
	import pdrk_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] num,
	input  wire logic [SUM_W-1:0] den,
	output      div_result_t      res
);

	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [GAIN_W-1:0] quo_q;
	logic [SUM_W:0]    rem2;
	logic              ge;
	logic [SUM_W-1:0]  rem_next;

	always_comb begin
		rem2     = {rem_q, 1'b0};
		ge       = rem2 >= {1'b0, den_q};
		rem_next = ge ? SUM_W'(rem2 - {1'b0, den_q}) : SUM_W'(rem2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(GAIN_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[GAIN_W-2:0], ge};
		end
	end

	assign res.done     = busy_q && (cnt_q == '0);
	assign res.quotient = quo_q;

	`PDRK_ASSERT(a_div_start_idle, start |-> !busy_q, "divider started while busy")
	`PDRK_ASSERT(a_div_latency, start |-> ##(GAIN_W + 1) res.done, "divider result late")

endmodule
`default_nettype wire

@@ rtl/pdrk_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module pdrk_mul
	import pdrk_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output      logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

@@ rtl/per_device_rssi_kalman_unit.sv @@
// Top level of the per-slot RSSI Kalman filter with its sequencer and slot tables.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tdata: device_slot[5:0], rssi_sample[21:6]
// m_*      out  tdata: slot_echo[5:0], filtered_rssi[21:6]; tuser: first_sample
// cfg_*    in   index 0 process_noise, index 1 measurement_noise
//
// A beat for a new slot passes the read and write states and is registered as a result.
// A seen slot adds divider, multiply and variance states; the gain divider has 16 steps.
// With a zero measurement noise the divider is skipped for a seen slot.
// s_tready returns in the same cycle that the registered result raises m_tvalid.
// Reset clears the seen flags; table entries are read only once written.
// A result waiting on m_tready holds the next item in the write stage, with s_tready low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module per_device_rssi_kalman_unit
	import pdrk_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // device_slot, rssi_sample
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [OUT_DATA_W-1:0] m_tdata,   // slot_echo, filtered_rssi
	output      logic [0:0]            m_tuser,   // first_sample
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_BITS-1:0]   cfg_data
);

	state_t state_q;
	state_t state_next;

	logic [CFG_BITS-1:0]         pn_q;
	logic [CFG_BITS-1:0]         mn_q;
	logic [SLOT_COUNT-1:0]       seen_q;
	logic [SLOT_FIELD_BITS-1:0]  slot_field_q;
	logic [SLOT_W-1:0]           slot_q;
	logic signed [RSSI_BITS-1:0] sample_q;
	logic signed [RSSI_BITS-1:0] est_q;
	logic [VARIANCE_BITS-1:0]    pred_q;
	logic [VARIANCE_BITS-1:0]    var_q;
	logic [GAIN_W-1:0]           gain_q;
	logic                        first_q;

	logic                        m_tvalid_q;
	logic [SLOT_FIELD_BITS-1:0]  m_slot_q;
	logic [RSSI_BITS-1:0]        m_rssi_q;
	logic                        m_first_q;

	logic [SLOT_W-1:0]           in_slot;
	logic [SLOT_W-1:0]           ram_addr;
	logic                        ram_we;
	logic [RSSI_BITS-1:0]        est_rd;
	logic [VARIANCE_BITS-1:0]    var_rd;
	logic [SUM_W-1:0]            pred_sum;
	logic [SUM_W-1:0]            den;
	logic                        div_trivial;
	logic                        div_start;
	div_result_t                 div_res;
	logic signed [RSSI_BITS:0]   diff;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [MUL_P_W-1:0]   mul_p;
	logic                        out_free;
	logic                        in_beat;

	assign in_slot     = SLOT_W'(s_tdata[SLOT_FIELD_BITS-1:0] % SLOT_COUNT);
	assign in_beat     = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign pred_sum    = SUM_W'(var_rd) + SUM_W'(pn_q);
	assign den         = SUM_W'(pred_q) + SUM_W'(mn_q);
	assign div_trivial = (den == '0) || (SUM_W'(pred_q) >= den);
	assign diff        = $signed({sample_q[RSSI_BITS-1], sample_q})
	                   - $signed({est_q[RSSI_BITS-1], est_q});
	assign cfg_ready   = 1'b1;

	pdrk_ram #(.WIDTH(RSSI_BITS), .DEPTH(SLOT_COUNT)) u_est_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (est_q),
		.rdata (est_rd)
	);

	pdrk_ram #(.WIDTH(VARIANCE_BITS), .DEPTH(SLOT_COUNT)) u_var_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (var_q),
		.rdata (var_rd)
	);

	pdrk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (SUM_W'(pred_q)),
		.den    (den),
		.res    (div_res)
	);

	pdrk_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = seen_q[slot_q] ? ST_DIV_START : ST_WRITE;
			end
			ST_DIV_START: begin
				state_next = div_trivial ? ST_MUL_EST : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_res.done) begin
					state_next = ST_MUL_EST;
				end
			end
			ST_MUL_EST: state_next = ST_MUL_VAR;
			ST_MUL_VAR: state_next = ST_VAR;
			ST_VAR:     state_next = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = in_slot;
		div_start = 1'b0;
		mul_a     = MUL_A_W'($signed({1'b0, gain_q}));
		mul_b     = MUL_B_W'(diff);
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DIV_START: div_start = !div_trivial;
			ST_MUL_VAR: begin
				mul_a = MUL_A_W'($signed({1'b0, ONE_Q16 - {1'b0, gain_q}}));
				mul_b = MUL_B_W'($signed({1'b0, pred_q}));
			end
			ST_WRITE: begin
				ram_addr = slot_q;
				ram_we   = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pn_q       <= PROCESS_NOISE_RESET;
			mn_q       <= MEASUREMENT_NOISE_RESET;
			seen_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROCESS_NOISE:     pn_q <= cfg_data;
					REG_MEASUREMENT_NOISE: mn_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_WRITE && out_free) begin
				seen_q[slot_q] <= 1'b1;
				m_tvalid_q     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			slot_field_q <= s_tdata[SLOT_FIELD_BITS-1:0];
			slot_q       <= in_slot;
			sample_q     <= s_tdata[SLOT_FIELD_BITS +: RSSI_BITS];
		end
		case (state_q)
			ST_READ: begin
				first_q <= !seen_q[slot_q];
				if (seen_q[slot_q]) begin
					est_q  <= est_rd;
					pred_q <= (pred_sum > SUM_W'(VAR_MAX)) ? VAR_MAX
					                                        : VARIANCE_BITS'(pred_sum);
				end else begin
					est_q <= sample_q;
					var_q <= VAR_INIT;
				end
			end
			ST_DIV_START: gain_q <= (den == '0) ? '0 : GAIN_MAX;
			ST_DIV_WAIT: begin
				if (div_res.done) begin
					gain_q <= div_res.quotient;
				end
			end
			ST_MUL_VAR: est_q <= est_q + RSSI_BITS'(mul_p >>> GAIN_W);
			ST_VAR:     var_q <= mul_p[GAIN_W +: VARIANCE_BITS];
			ST_WRITE: begin
				if (out_free) begin
					m_slot_q  <= slot_field_q;
					m_rssi_q  <= est_q;
					m_first_q <= first_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({m_rssi_q, m_slot_q});
	assign m_tuser  = m_first_q;

	`PDRK_ASSERT(a_out_from_write, $rose(m_tvalid_q) |-> $past(state_q == ST_WRITE), "stray beat")
	`PDRK_ASSERT_NEXT(a_accept_reads, in_beat, state_q == ST_READ, "accepted beat did not start a table read")
	`PDRK_ASSERT(a_div_only_seen, div_start |-> seen_q[slot_q], "gain division for an unseen slot")

endmodule
`default_nettype wire
